// File: rtl/core/edtc_pkg.sv
// Shared constants, state encoding and controller/datapath interface types
// for the edit distance compare block. No dependencies.
`timescale 1ns / 1ps

package edtc_pkg;

  localparam int MAX_LEN  = 512;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int FUNC_W   = 2;
  localparam int CHAR_W   = 8;
  localparam int THR_W    = 10;
  localparam int DIST_W   = 10;
  localparam int CMP_W    = (LEN_W > DIST_W) ? LEN_W : DIST_W;
  localparam int DIST_SAT = (1 << DIST_W) - 1;

  localparam logic [FUNC_W-1:0] FUNC_LOAD1   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD2   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPARE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW_START,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_FINISH
  } edtc_state_t;

  typedef struct packed {
    logic start;
    logic init_step;
    logic row_start;
    logic cell_rd;
    logic cell_wr;
    logic finish;
  } edtc_cmd_t;

  typedef struct packed {
    logic n1_zero;
    logic n2_zero;
    logic init_last;
    logic col_last;
    logic row_last;
    logic out_free;
  } edtc_status_t;

endpackage

// File: rtl/core/edtc_datapath.sv
// Datapath: string buffers, DP row memory, counters, cell arithmetic and
// the result register. Depends on edtc_pkg; driven by edtc_ctrl commands.
`timescale 1ns / 1ps

module edtc_datapath import edtc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_take,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [CHAR_W-1:0]   in_ch,
  input  logic [THR_W-1:0]    in_threshold,
  input  edtc_cmd_t           cmd,
  output edtc_status_t        status,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [DIST_W-1:0]   out_distance,
  output logic                out_similar
);

  logic [CHAR_W-1:0] t1_mem [MAX_LEN];
  logic [CHAR_W-1:0] t2_mem [MAX_LEN];
  logic [LEN_W-1:0]  row_mem [MAX_LEN];

  logic [LEN_W-1:0]  len1_r, len2_r;
  logic [ADDR_W-1:0] i_r, j_r, k_r;
  logic [LEN_W-1:0]  left_r, diag_r, up_r;
  logic [CHAR_W-1:0] t1_q_r, t2_q_r;
  logic [THR_W-1:0]  thr_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_distance_r;
  logic              out_similar_r;

  logic              wr1, wr2;
  logic [LEN_W-1:0]  len1_m1, len2_m1;
  logic [LEN_W:0]    c_left, c_up, c_diag, c_min;
  logic [LEN_W-1:0]  cell_val;
  logic              row_we;
  logic [ADDR_W-1:0] row_wa;
  logic [LEN_W-1:0]  row_wd;
  logic [LEN_W-1:0]  d_sel;
  logic [CMP_W-1:0]  d_ext;

  assign wr1 = in_take && (in_func == FUNC_LOAD1) && (len1_r < LEN_W'(MAX_LEN));
  assign wr2 = in_take && (in_func == FUNC_LOAD2) && (len2_r < LEN_W'(MAX_LEN));

  assign len1_m1 = len1_r - LEN_W'(1);
  assign len2_m1 = len2_r - LEN_W'(1);

  // One DP cell: min of insertion, deletion and substitution.
  always_comb begin
    c_left = {1'b0, left_r} + (LEN_W+1)'(1);
    c_up   = {1'b0, up_r} + (LEN_W+1)'(1);
    c_diag = {1'b0, diag_r} + (LEN_W+1)'(t1_q_r != t2_q_r);
    c_min  = (c_left < c_up) ? c_left : c_up;
    if (c_diag < c_min) begin
      c_min = c_diag;
    end
    cell_val = c_min[LEN_W-1:0];
  end

  // Row entry at address k holds column k+1; column 0 is implied by the row index.
  assign row_we = cmd.init_step || cmd.cell_wr;
  assign row_wa = cmd.init_step ? k_r : j_r;
  assign row_wd = cmd.init_step ? (LEN_W'(k_r) + LEN_W'(1)) : cell_val;

  always_ff @(posedge clk) begin
    if (wr1) begin
      t1_mem[len1_r[ADDR_W-1:0]] <= in_ch;
    end
    if (wr2) begin
      t2_mem[len2_r[ADDR_W-1:0]] <= in_ch;
    end
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    if (cmd.row_start) begin
      t1_q_r <= t1_mem[i_r];
    end
    if (cmd.cell_rd) begin
      t2_q_r <= t2_mem[j_r];
      up_r   <= row_mem[j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      k_r   <= '0;
      i_r   <= '0;
      thr_r <= in_threshold;
    end
    if (cmd.init_step) begin
      k_r <= k_r + ADDR_W'(1);
    end
    if (cmd.row_start) begin
      j_r    <= '0;
      diag_r <= LEN_W'(i_r);
      left_r <= LEN_W'(i_r) + LEN_W'(1);
    end
    if (cmd.cell_wr) begin
      left_r <= cell_val;
      diag_r <= up_r;
      j_r    <= j_r + ADDR_W'(1);
      if (status.col_last) begin
        i_r <= i_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len1_r <= '0;
      len2_r <= '0;
    end else if (cmd.finish) begin
      len1_r <= '0;
      len2_r <= '0;
    end else begin
      if (wr1) begin
        len1_r <= len1_r + LEN_W'(1);
      end
      if (wr2) begin
        len2_r <= len2_r + LEN_W'(1);
      end
    end
  end

  // With one string empty the distance is the other length.
  assign d_sel = (status.n1_zero || status.n2_zero) ? (len1_r | len2_r) : left_r;
  assign d_ext = CMP_W'(d_sel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_distance_r <= (d_ext > CMP_W'(DIST_SAT)) ? DIST_W'(DIST_SAT) : DIST_W'(d_ext);
      out_similar_r  <= (d_sel == '0) ||
                        ((thr_r != '0) && (d_ext <= CMP_W'(thr_r)));
    end
  end

  assign status.n1_zero   = (len1_r == '0);
  assign status.n2_zero   = (len2_r == '0);
  assign status.init_last = (k_r == len2_m1[ADDR_W-1:0]);
  assign status.col_last  = (j_r == len2_m1[ADDR_W-1:0]);
  assign status.row_last  = (i_r == len1_m1[ADDR_W-1:0]);
  assign status.out_free  = !out_valid_r || !out_stall;

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_similar  = out_similar_r;

endmodule

// File: rtl/core/edtc_ctrl.sv
// Controller: sequences row init, the DP grid walk and result issue.
// Depends on edtc_pkg; commands edtc_datapath.
`timescale 1ns / 1ps

module edtc_ctrl import edtc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cmp_req,
  input  edtc_status_t status,
  output edtc_cmd_t    cmd,
  output logic         busy
);

  edtc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmp_req) begin
          cmd.start = 1'b1;
          state_nxt = (status.n1_zero || status.n2_zero) ? ST_FINISH : ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (status.init_last) begin
          state_nxt = ST_ROW_START;
        end
      end
      ST_ROW_START: begin
        cmd.row_start = 1'b1;
        state_nxt     = ST_CELL_RD;
      end
      ST_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = ST_CELL_WR;
      end
      ST_CELL_WR: begin
        cmd.cell_wr = 1'b1;
        if (status.col_last) begin
          state_nxt = status.row_last ? ST_FINISH : ST_ROW_START;
        end else begin
          state_nxt = ST_CELL_RD;
        end
      end
      ST_FINISH: begin
        // hold until the result register is free
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: rtl/core/edit_distance_threshold_compare_top.sv
// Edit distance compare block. Each append transaction adds a byte to the
// first or second string (dropped once MAX_LEN are held).
// A compare transaction stalls the input until its result is registered;
// when either string is empty it goes straight to the result. Otherwise the
// single DP row memory is first filled with the initial row (one entry a
// cycle) and then walked grid cell by grid cell (read, then write back).
// Appends are taken while a finished result still waits on out_stall.
// Top level; depends on edtc_pkg, edtc_ctrl and edtc_datapath.
`timescale 1ns / 1ps

module edit_distance_threshold_compare_top import edtc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   in_func,
  input  logic [CHAR_W-1:0]   in_ch,
  input  logic [THR_W-1:0]    in_threshold,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DIST_W-1:0]   out_distance,
  output logic                out_similar
);

  edtc_cmd_t    cmd;
  edtc_status_t status;
  logic         busy;
  logic         in_take;
  logic         cmp_req;

  assign in_stall = busy;
  assign in_take  = in_valid && !busy;
  assign cmp_req  = in_take && (in_func == FUNC_COMPARE);

  edtc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmp_req (cmp_req),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  edtc_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_take      (in_take),
    .in_func      (in_func),
    .in_ch        (in_ch),
    .in_threshold (in_threshold),
    .cmd          (cmd),
    .status       (status),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_distance (out_distance),
    .out_similar  (out_similar)
  );

  // A compare transaction must block the input on the next cycle.
  a_cmp_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_req |=> in_stall)
    else $error("compare transaction did not stall the input");

  // Zero distance means equal strings, which are always similar.
  a_zero_similar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_distance == '0)) |-> out_similar)
    else $error("zero distance reported as not similar");

  // A result only appears at the end of a compare.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result issued outside a compare");

  // The sequencer only runs after a compare transaction.
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(cmp_req))
    else $error("sequencer started without a compare transaction");

endmodule
